// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define LPHI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lphi assertion failed");

// clocked assertion that also holds across reset
`define LPHI_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lphi assertion failed");

`endif

// ===== sv/lphi_pkg.sv =====
// types and constants of the linear probing hash index
package lphi_pkg;

  // payload widths
  localparam int ID_W     = 31;
  localparam int SCORE_W  = 10;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 5;

  // start slot reduction: reciprocal scale and number of steps
  localparam int RECIP_SHIFT = 32;
  localparam int MOD_STEPS   = 3;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_FIND = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_STORE_FULL = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_FOUND      = 3'd3,
    ST_MISSING    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_CHECK,
    S_SCORE,
    S_EMIT
  } lphi_state_t;

endpackage

// ===== sv/lphi_if.sv =====
// request and result channel interfaces
interface lphi_in_if
  import lphi_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ID_W-1:0]    student_id;
  logic [SCORE_W-1:0] new_score;

  modport source (output valid, req_type, student_id, new_score, input ready);
  modport sink   (input valid, req_type, student_id, new_score, output ready);
endinterface

interface lphi_out_if
  import lphi_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    record_index;
  logic [SCORE_W-1:0]  found_score;

  modport source (output valid, status, record_index, found_score, input ready);
  modport sink   (input valid, status, record_index, found_score, output ready);
endinterface

// ===== sv/lphi_ram.sv =====
// generic single write port ram with registered read
module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/linear_probe_hash_index_core.sv =====
// Keyed record store with a linear probing slot index. After reset the block
// sweeps the slot memory empty, one slot a cycle, and takes no request
// meanwhile. A request is then accepted, the id is reduced modulo SLOT_COUNT
// in the S_MOD state (skipped when SLOT_COUNT is a power of two), the first
// slot read is issued, each slot is probed in turn (1 to SLOT_COUNT of them,
// set by occupancy and clustering around the start slot), a successful find
// reads the score, and the result register is loaded once the output is free.
// An add to a full record store skips the reduction and the probe. The slot
// memory's single read port, read once per probe, sets the rate. A new
// request is taken while the previous result still waits.
module linear_probe_hash_index_core
  import lphi_pkg::*;
#(
  parameter int SLOT_COUNT   = 64,
  parameter int RECORD_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lphi_in_if.sink    in_ch,
  lphi_out_if.source out_ch
);
  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int RIW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam int RCW = $clog2(RECORD_COUNT + 1);
  localparam bit IS_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
  localparam int SLOT_W = 1 + ID_W + RIW;
  localparam int PROD_W = ID_W + RECIP_SHIFT;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / SLOT_COUNT;
  localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(RECIP_FULL);
  localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [SW:0]    MODULUS   = (SW + 1)'(SLOT_COUNT);
  localparam logic [RCW-1:0] REC_FULL  = RCW'(RECORD_COUNT);
  localparam logic [1:0]     LAST_DIG  = 2'(MOD_STEPS - 1);

  typedef struct packed {
    logic            used;
    logic [ID_W-1:0] key;
    logic [RIW-1:0]  rec;
  } slot_t;

  // control and payload registers
  lphi_state_t        state_r, state_nxt;
  req_t               op_r, op_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [SW:0]        mod_q_r, mod_q_nxt;
  logic [SW:0]        mod_d_r, mod_d_nxt;
  logic [1:0]         dig_r, dig_nxt;
  logic [SW-1:0]      pos_r, pos_nxt;
  logic [SW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      clr_r, clr_nxt;
  logic [RIW-1:0]     idx_r, idx_nxt;
  logic [RCW-1:0]     count_r, count_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [RIW-1:0]     res_idx_r, res_idx_nxt;
  logic [SCORE_W-1:0] res_score_r, res_score_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;

  // memory ports
  logic               slot_we;
  logic [SW-1:0]      slot_waddr, slot_raddr;
  slot_t              slot_wdata, slot_rd;
  logic [SLOT_W-1:0]  slot_rdata;
  logic               rec_we;
  logic [RIW-1:0]     rec_waddr, rec_raddr;
  logic [SCORE_W-1:0] rec_wdata, rec_rdata;

  // decode helpers
  logic               in_fire;
  logic               out_free;
  logic               rec_full;
  logic               hit_empty;
  logic               hit_key;
  logic               last_probe;
  logic [SW-1:0]      pos_inc;
  logic [PROD_W-1:0]  mod_prod;
  logic [SW:0]        mod_qm;
  logic [SW-1:0]      mod_rem;
  logic [SW:0]        mod_t;
  logic [RIW+IDX_W-1:0] res_idx_ext;

  lphi_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  lphi_ram #(.WIDTH(SCORE_W), .DEPTH(RECORD_COUNT)) u_score_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid && (state_r == S_IDLE);
  assign out_free            = !out_valid_r || out_ch.ready;
  assign rec_full            = (count_r == REC_FULL);
  assign slot_rd             = slot_t'(slot_rdata);
  assign hit_empty           = !slot_rd.used;
  assign hit_key             = slot_rd.used && (slot_rd.key == id_r);
  assign last_probe          = (cnt_r == LAST_SLOT);
  assign pos_inc             = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;
  assign res_idx_ext         = {{IDX_W{1'b0}}, res_idx_r};

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.record_index = out_idx_r;
  assign out_ch.found_score  = out_score_r;

  // start slot reduction: quotient estimate from the reciprocal, low bits of
  // the remainder (below twice the modulus), then one correcting subtract
  always_comb begin
    mod_prod = PROD_W'(id_r) * PROD_W'(RECIP);
    mod_qm   = mod_q_r * MODULUS;
    mod_t    = mod_d_r - MODULUS;
    mod_rem  = (mod_d_r >= MODULUS) ? mod_t[SW-1:0] : mod_d_r[SW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_SLOT) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (req_t'(in_ch.req_type) == REQ_ADD && rec_full) state_nxt = S_EMIT;
          else if (IS_POW2)                                   state_nxt = S_PROBE;
          else                                                state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (dig_r == LAST_DIG) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (op_r == REQ_FIND && hit_key)      state_nxt = S_SCORE;
        else if (hit_empty || last_probe)     state_nxt = S_EMIT;
      end
      S_SCORE: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    mod_q_nxt      = mod_q_r;
    mod_d_nxt      = mod_d_r;
    dig_nxt        = dig_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_score_nxt  = res_score_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_score_nxt  = out_score_r;
    slot_we        = 1'b0;
    slot_waddr     = pos_r;
    slot_wdata     = '{used: 1'b1, key: id_r, rec: idx_r};
    slot_raddr     = (state_r == S_CHECK) ? pos_inc : pos_r;
    rec_we         = 1'b0;
    rec_waddr      = count_r[RIW-1:0];
    rec_wdata      = in_ch.new_score;
    rec_raddr      = slot_rd.rec;

    case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt  = req_t'(in_ch.req_type);
          id_nxt  = in_ch.student_id;
          dig_nxt = '0;
          pos_nxt = IS_POW2 ? in_ch.student_id[SW-1:0] : '0;
          cnt_nxt = '0;
          if (req_t'(in_ch.req_type) == REQ_ADD) begin
            if (rec_full) begin
              res_status_nxt = ST_STORE_FULL;
              res_idx_nxt    = '0;
              res_score_nxt  = '0;
            end else begin
              rec_we    = 1'b1;
              idx_nxt   = count_r[RIW-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
        end
      end
      S_MOD: begin
        dig_nxt = dig_r + 1'b1;
        if (dig_r == 2'd0) begin
          mod_q_nxt = mod_prod[RECIP_SHIFT +: SW + 1];
        end else if (dig_r == 2'd1) begin
          mod_d_nxt = id_r[SW:0] - mod_qm;
        end else begin
          pos_nxt = mod_rem;
        end
      end
      S_CHECK: begin
        cnt_nxt       = cnt_r + 1'b1;
        pos_nxt       = pos_inc;
        res_score_nxt = '0;
        if (op_r == REQ_ADD) begin
          res_idx_nxt = idx_r;
          if (hit_empty) begin
            slot_we        = 1'b1;
            res_status_nxt = ST_ADDED;
          end else begin
            res_status_nxt = ST_TABLE_FULL;
          end
        end else begin
          if (!hit_empty && hit_key) begin
            res_status_nxt = ST_FOUND;
            res_idx_nxt    = slot_rd.rec;
          end else begin
            res_status_nxt = ST_MISSING;
            res_idx_nxt    = '0;
          end
        end
      end
      S_SCORE: begin
        res_score_nxt = rec_rdata;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_ext[IDX_W-1:0];
          out_score_nxt  = res_score_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    mod_q_r      <= mod_q_nxt;
    mod_d_r      <= mod_d_nxt;
    dig_r        <= dig_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_score_r  <= res_score_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_score_r  <= out_score_nxt;
  end
endmodule

// ===== sv/lphi_checker.sv =====
// port level checks of the hash index core, bound into the core module
`include "assert_macros.svh"

module lphi_checker
  import lphi_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [IDX_W-1:0]    out_record_index,
  input logic [SCORE_W-1:0]  out_found_score
);
  logic       in_fire;
  logic       out_fire;
  logic       no_payload;
  logic       payload_zero;
  logic [STATUS_W+IDX_W+SCORE_W-1:0] out_beat;
  logic [1:0] pending_r, pending_nxt;

  assign in_fire      = in_valid && in_ready;
  assign out_fire     = out_valid && out_ready;
  assign no_payload   = (out_status == ST_STORE_FULL) || (out_status == ST_MISSING);
  assign payload_zero = (out_record_index == '0) && (out_found_score == '0);
  assign out_beat     = {out_status, out_record_index, out_found_score};

  // requests accepted whose result beat has not gone out yet
  always_comb begin
    pending_nxt = pending_r + {1'b0, in_fire} - {1'b0, out_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // every result beat answers an accepted request
  `LPHI_ASSERT(a_result_has_request, out_fire |-> pending_r != 2'd0)

  // at most one result may wait when a new request comes in
  `LPHI_ASSERT(a_pending_bound, in_fire |-> pending_r < 2'd2)

  // rejected adds and misses carry no record and no score
  `LPHI_ASSERT(a_empty_fields, out_valid && no_payload |-> payload_zero)

  // a stalled result beat holds
  `LPHI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat))

  // no request is taken in the cycle after reset is seen
  `LPHI_ASSERT_RST(a_reset_blocks_input, !rst_n |=> !in_ready)
endmodule

bind linear_probe_hash_index_core lphi_checker u_lphi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_record_index (out_ch.record_index),
  .out_found_score  (out_ch.found_score)
);
